FILE: src/bps_pkg.sv
// package: types, codes and melody tables for the buzzer pattern sequencer
`timescale 1ns / 1ps

package bps_pkg;

  // default channel count
  localparam int unsigned CHANNELS_DEF = 4;

  // channels that appear in the result fields
  localparam int unsigned OUT_CHANNELS = 4;

  // item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // melody selector codes
  localparam logic [1:0] MEL_STOP = 2'd0;
  localparam logic [1:0] MEL_ONE  = 2'd1;
  localparam logic [1:0] MEL_TWO  = 2'd2;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_MEL = 1'b1;

  // entry layout: level in the top bit, duration below
  localparam logic [31:0] LEVEL_BIT = 32'h8000_0000;
  localparam int unsigned LEVEL_POS = 31;

  // melody lengths
  localparam int unsigned MEL1_LEN = 19;
  localparam int unsigned MEL2_LEN = 2;

  localparam logic [31:0] TUNE_ONE [MEL1_LEN] = '{
    LEVEL_BIT | 32'd100, 32'd900,
    LEVEL_BIT | 32'd100, 32'd800,
    LEVEL_BIT | 32'd100, 32'd700,
    LEVEL_BIT | 32'd100, 32'd600,
    LEVEL_BIT | 32'd100, 32'd500,
    LEVEL_BIT | 32'd100, 32'd400,
    LEVEL_BIT | 32'd100, 32'd300,
    LEVEL_BIT | 32'd100, 32'd200,
    LEVEL_BIT | 32'd100, 32'd100,
    LEVEL_BIT | 32'd1000
  };

  localparam logic [31:0] TUNE_TWO [MEL2_LEN] = '{
    LEVEL_BIT | 32'd20, 32'd20
  };

  // per-channel playback state
  typedef struct packed {
    logic [4:0]  pos;
    logic [31:0] deadline;
    logic [1:0]  mel;
    logic        rep;
    logic        playing;
    logic        level;
  } chan_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_RESP
  } fsm_e;

  // number of entries in a melody, zero for an unknown selector
  function automatic logic [4:0] tune_length(logic [1:0] sel);
    logic [4:0] len;
    len = 5'd0;
    if (sel == MEL_ONE) len = 5'(MEL1_LEN);
    else if (sel == MEL_TWO) len = 5'(MEL2_LEN);
    return len;
  endfunction

  // melody entry lookup, zero outside the melody
  function automatic logic [31:0] tune_entry(logic [1:0] sel, logic [4:0] pos);
    logic [31:0] e;
    e = 32'd0;
    if (sel == MEL_ONE && pos < 5'(MEL1_LEN)) e = TUNE_ONE[pos];
    else if (sel == MEL_TWO && pos < 5'(MEL2_LEN)) e = TUNE_TWO[pos[0]];
    return e;
  endfunction

endpackage

FILE: src/buzzer_pattern_sequencer_top.sv
// top level: request sequencer, per-channel state and result port
// a tick request is accepted, then one channel is updated per cycle by the
// shared step unit, after which its result is offered;
// a set-melody request is applied in the command state before its result is offered
// no new request is accepted until the result of the last one is taken
// reset (async, active low): all channels stopped, outputs low, port idle
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_top #(
  parameter int unsigned CHANNELS = bps_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [1:0]  channel_i,
  input  logic [1:0]  melody_id_i,
  input  logic        repeat_enable_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  output_levels_o,
  output logic [3:0]  active_mask_o,
  output logic        status_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  bps_pkg::fsm_e  state_q, state_d;
  bps_pkg::chan_t chan_q [CHANNELS];
  bps_pkg::chan_t chan_d [CHANNELS];
  logic [CH_W-1:0] idx_q, idx_d;
  logic            status_q, status_d;

  // latched request
  logic        cmd_q;
  logic [1:0]  chan_sel_q;
  logic [1:0]  mel_q;
  logic        rep_q;
  logic [31:0] now_q;

  logic            in_accept;
  logic [4:0]      chan_ext;
  logic            chan_ok;
  logic [CH_W-1:0] cmd_idx;
  bps_pkg::chan_t  step_cur;
  bps_pkg::chan_t  step_nxt;

  assign in_accept = in_valid_i && !in_stall_o;
  assign chan_ext  = {3'b000, chan_sel_q};
  assign chan_ok   = (chan_ext < 5'(CHANNELS));
  assign cmd_idx   = chan_ext[CH_W-1:0];
  assign step_cur  = chan_q[idx_q];

  // shared channel update unit
  bps_step u_step (
    .now_i   (now_q),
    .cur_i   (step_cur),
    .nxt_i_o (step_nxt)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= command_i;
      chan_sel_q <= channel_i;
      mel_q      <= melody_id_i;
      rep_q      <= repeat_enable_i;
      now_q      <= now_ms_i;
    end
  end

  // sequencer next state and channel updates
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    status_d = status_q;
    for (int c = 0; c < CHANNELS; c++) chan_d[c] = chan_q[c];
    case (state_q)
      bps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          idx_d    = '0;
          status_d = bps_pkg::STATUS_OK;
          state_d  = (command_i == bps_pkg::CMD_TICK) ? bps_pkg::ST_SCAN : bps_pkg::ST_CMD;
        end
      end
      bps_pkg::ST_CMD: begin
        if (chan_ok) begin
          case (mel_q)
            bps_pkg::MEL_STOP: begin
              chan_d[cmd_idx].playing = 1'b0;
              chan_d[cmd_idx].level   = 1'b0;
            end
            bps_pkg::MEL_ONE, bps_pkg::MEL_TWO: begin
              chan_d[cmd_idx].mel      = mel_q;
              chan_d[cmd_idx].pos      = 5'd0;
              chan_d[cmd_idx].rep      = rep_q;
              chan_d[cmd_idx].playing  = 1'b1;
              chan_d[cmd_idx].deadline = 32'd0;
            end
            default: status_d = bps_pkg::STATUS_BAD_MEL;
          endcase
        end
        state_d = bps_pkg::ST_RESP;
      end
      bps_pkg::ST_SCAN: begin
        chan_d[idx_q] = step_nxt;
        if (idx_q == LAST_CH) state_d = bps_pkg::ST_RESP;
        else idx_d = idx_q + 1'b1;
      end
      bps_pkg::ST_RESP: begin
        if (!out_stall_i) state_d = bps_pkg::ST_IDLE;
      end
      default: state_d = bps_pkg::ST_IDLE;
    endcase
  end

  // control and channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bps_pkg::ST_IDLE;
      idx_q    <= '0;
      status_q <= bps_pkg::STATUS_OK;
      for (int c = 0; c < CHANNELS; c++) chan_q[c] <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      for (int c = 0; c < CHANNELS; c++) chan_q[c] <= chan_d[c];
    end
  end

  // handshake
  assign in_stall_o  = (state_q != bps_pkg::ST_IDLE);
  assign out_valid_o = (state_q == bps_pkg::ST_RESP);
  assign status_o    = status_q;

  // result fields, first four channels only
  for (genvar g = 0; g < bps_pkg::OUT_CHANNELS; g++) begin : g_out
    if (g < CHANNELS) begin : g_used
      assign output_levels_o[g] = chan_q[g].level;
      assign active_mask_o[g]   = chan_q[g].playing;
    end else begin : g_unused
      assign output_levels_o[g] = 1'b0;
      assign active_mask_o[g]   = 1'b0;
    end
  end

  // a result on offer holds the input side off
  a_resp_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input open");

  // a sounding channel is always a playing channel
  a_level_needs_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (output_levels_o & ~active_mask_o) == 4'b0000)
    else $error("drive level set on stopped channel");

  // scan index stays within the channel range
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bps_pkg::ST_SCAN) |-> (idx_q <= LAST_CH))
    else $error("scan index out of range");

  // a rejected melody only follows a set-melody request
  a_status_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bps_pkg::STATUS_BAD_MEL) |-> (cmd_q == bps_pkg::CMD_SET))
    else $error("bad melody status on a tick");

endmodule

FILE: src/bps_step.sv
// shared channel update unit: deadline compare, entry fetch and deadline add
`timescale 1ns / 1ps

module bps_step (
  input  logic [31:0]         now_i,
  input  bps_pkg::chan_t      cur_i,
  output bps_pkg::chan_t      nxt_i_o
);

  logic [4:0]  len;
  logic [4:0]  pos_eff;
  logic        at_end;
  logic        halt;
  logic        due;
  logic [31:0] entry;

  // melody end handling and entry fetch
  always_comb begin
    len     = bps_pkg::tune_length(cur_i.mel);
    at_end  = (cur_i.pos >= len);
    halt    = at_end && (!cur_i.rep || len == 5'd0);
    pos_eff = at_end ? 5'd0 : cur_i.pos;
    entry   = bps_pkg::tune_entry(cur_i.mel, pos_eff);
    due     = cur_i.playing && (now_i >= cur_i.deadline);
  end

  // next channel state
  always_comb begin
    nxt_i_o = cur_i;
    if (due) begin
      if (halt) begin
        nxt_i_o.playing = 1'b0;
        nxt_i_o.level   = 1'b0;
      end else begin
        nxt_i_o.pos      = pos_eff + 5'd1;
        nxt_i_o.deadline = now_i + {1'b0, entry[30:0]};
        nxt_i_o.level    = entry[bps_pkg::LEVEL_POS];
      end
    end
  end

endmodule
